// File: sv/pcbe_pkg.sv
// ----------------------------------------------------------------------------
// pcbe_pkg: shared types for the cubic bezier evaluator
// transaction payloads, action codes and controller-to-datapath commands
// ----------------------------------------------------------------------------
package pcbe_pkg;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_EVAL   = 2'd2;

    localparam int STEP_W = 4;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         point_index;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] tangent_factor;
        logic [16:0]        param_t;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               status;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_APPEND_RD0,
        OP_APPEND_RD1,
        OP_APPEND_DIFF,
        OP_APPEND_MUL,
        OP_APPEND_WR,
        OP_EVAL_SEG,
        OP_EVAL_SQ,
        OP_EVAL_W,
        OP_EVAL_W0,
        OP_EVAL_MAC,
        OP_EVAL_RND
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STEP_W-1:0]   step;
        logic                load;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
    } t_dp_sts;

endpackage

// File: sv/pcbe_if.sv
// ----------------------------------------------------------------------------
// pcbe_in_if / pcbe_out_if: valid-ready channels
// input item channel and result channel of the bezier evaluator
// ----------------------------------------------------------------------------
interface pcbe_in_if;
    import pcbe_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcbe_out_if;
    import pcbe_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/pcbe_ctrl.sv
// ----------------------------------------------------------------------------
// pcbe_ctrl: sequencer of the bezier evaluator
// walks each action through its datapath steps and owns the result valid
// ----------------------------------------------------------------------------
module pcbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_action,
    input  pcbe_pkg::t_dp_sts i_sts,
    output pcbe_pkg::t_dp_cmd o_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import pcbe_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_WRITE  = 14'h0002,
        S_ARD0   = 14'h0004,
        S_ARD1   = 14'h0008,
        S_ADIFF  = 14'h0010,
        S_AMUL   = 14'h0020,
        S_AWR    = 14'h0040,
        S_ESEG   = 14'h0080,
        S_ESQ    = 14'h0100,
        S_EW     = 14'h0200,
        S_EW0    = 14'h0400,
        S_EMAC   = 14'h0800,
        S_ERND   = 14'h1000,
        S_DONE   = 14'h2000
    } t_state;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(8);
    localparam logic [STEP_W-1:0] WR_LAST  = STEP_W'(3);
    localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(4);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    case (i_action)
                        ACT_WRITE:  n_state = S_WRITE;
                        ACT_APPEND: n_state = i_sts.full ? S_DONE : S_ARD0;
                        ACT_EVAL:   n_state = S_ESEG;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: n_state = S_DONE;
            S_ARD0:  n_state = S_ARD1;
            S_ARD1:  n_state = S_ADIFF;
            S_ADIFF: n_state = S_AMUL;
            S_AMUL: begin
                if (r_step == MUL_LAST) begin
                    n_step  = '0;
                    n_state = S_AWR;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_AWR: begin
                if (r_step == WR_LAST) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_ESEG: n_state = S_ESQ;
            S_ESQ:  n_state = S_EW;
            S_EW:   n_state = S_EW0;
            S_EW0:  n_state = S_EMAC;
            S_EMAC: begin
                if (r_step == MAC_LAST) begin
                    n_step  = '0;
                    n_state = S_ERND;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_ERND: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        o_cmd.load     = accept;
        o_cmd.out_load = out_load;
        o_cmd.step     = r_step;
        case (r_state)
            S_WRITE: o_cmd.op = OP_WRITE;
            S_ARD0:  o_cmd.op = OP_APPEND_RD0;
            S_ARD1:  o_cmd.op = OP_APPEND_RD1;
            S_ADIFF: o_cmd.op = OP_APPEND_DIFF;
            S_AMUL:  o_cmd.op = OP_APPEND_MUL;
            S_AWR:   o_cmd.op = OP_APPEND_WR;
            S_ESEG:  o_cmd.op = OP_EVAL_SEG;
            S_ESQ:   o_cmd.op = OP_EVAL_SQ;
            S_EW:    o_cmd.op = OP_EVAL_W;
            S_EW0:   o_cmd.op = OP_EVAL_W0;
            S_EMAC:  o_cmd.op = OP_EVAL_MAC;
            S_ERND:  o_cmd.op = OP_EVAL_RND;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted transaction did not leave idle");

    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("finished result not presented");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result withdrawn before handover");
`endif

endmodule

// File: sv/pcbe_dp.sv
// ----------------------------------------------------------------------------
// pcbe_dp: datapath of the bezier evaluator
// control point memory, segment count, tangent multiplier and weighted sum
// ----------------------------------------------------------------------------
module pcbe_dp #(
    parameter int MAX_SEGMENTS    = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcbe_pkg::t_dp_cmd    i_cmd,
    input  pcbe_pkg::t_in_item   i_item,
    output pcbe_pkg::t_dp_sts    o_sts,
    output pcbe_pkg::t_out_item  o_out
);
    import pcbe_pkg::*;

    localparam int TABLE_SIZE = 4 * MAX_SEGMENTS;
    localparam int AW         = $clog2(TABLE_SIZE);
    localparam int SCW        = $clog2(MAX_SEGMENTS + 1);
    localparam logic signed [66:0] RND_POS = 67'sd1 <<< (COORD_FRAC_BITS - 1);
    localparam logic signed [66:0] RND_NEG = RND_POS - 67'sd1;
    localparam logic signed [66:0] RND_Q30 = 67'sd1 <<< 29;

    function automatic logic signed [31:0] f_sat(logic signed [66:0] v);
        if (v > 67'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -67'sh80000000) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // tangent steps: three per coordinate (low product, high product, round)
    function automatic logic [1:0] f_coord(logic [STEP_W-1:0] s);
        case (s)
            4'd0, 4'd1, 4'd2: return 2'd0;
            4'd3, 4'd4, 4'd5: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] f_phase(logic [STEP_W-1:0] s);
        case (s)
            4'd0, 4'd3, 4'd6: return 2'd0;
            4'd1, 4'd4, 4'd7: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    t_in_item           r_item;
    logic [95:0]        r_mem [TABLE_SIZE];
    logic [95:0]        r_rd;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [95:0]        wr_data;
    logic               wr_en;
    logic [SCW-1:0]     r_segcnt;
    logic               full;
    logic [AW-1:0]      base;

    logic [95:0]        r_p0;
    logic signed [33:0] r_d [3];
    logic signed [66:0] r_prod;
    logic signed [31:0] r_tan [3];
    logic signed [33:0] dsel;
    logic signed [17:0] opa;
    logic signed [49:0] mprod;
    logic [1:0]         coord, phase;

    logic [SCW-1:0]     r_seg;
    logic [15:0]        r_lt;
    logic [16:0]        r_u;
    logic [31:0]        r_ll;
    logic [32:0]        r_lu;
    logic [29:0]        r_w1, r_w2, r_w3;
    logic [30:0]        r_w0;
    logic signed [63:0] r_acc [3];
    logic [30:0]        wsel;

    logic [15:0]        tc;
    logic [16+SCW-1:0]  scaled;
    logic [SCW-1:0]     segraw;
    logic [16:0]        u;
    logic [47:0]        m3;
    logic [48:0]        m2;
    logic [49:0]        m1;
    logic [50:0]        m2x3;
    logic [51:0]        m1x3;

    t_out_item          r_res, r_out;

    assign full       = 32'(r_segcnt) >= 32'(MAX_SEGMENTS);
    assign o_sts.full = full;
    assign base       = AW'({r_segcnt, 2'b00});
    assign o_out      = r_out;
    assign coord      = f_coord(i_cmd.step);
    assign phase      = f_phase(i_cmd.step);

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = base + AW'(i_cmd.step);
        wr_data = r_p0;
        rd_addr = '0;
        case (i_cmd.op)
            OP_WRITE: begin
                wr_en   = (32'(r_item.point_index) < 32'(TABLE_SIZE));
                wr_addr = AW'(r_item.point_index);
                wr_data = {r_item.az, r_item.ay, r_item.ax};
            end
            OP_APPEND_RD0: rd_addr = base - AW'(1);
            OP_APPEND_RD1: rd_addr = base - AW'(2);
            OP_APPEND_WR: begin
                wr_en = 1'b1;
                case (i_cmd.step[1:0])
                    2'd0:    wr_data = r_p0;
                    2'd1:    wr_data = {r_tan[2], r_tan[1], r_tan[0]};
                    2'd2:    wr_data = {r_item.az, r_item.ay, r_item.ax};
                    default: wr_data = {r_item.bz, r_item.by_coord, r_item.bx};
                endcase
            end
            OP_EVAL_MAC: rd_addr = AW'({r_seg, 2'b00}) + AW'(i_cmd.step[1:0]);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segcnt <= SCW'(1);
        end else if (i_cmd.op == OP_WRITE && r_item.point_index == 6'd0) begin
            r_segcnt <= SCW'(1);
        end else if (i_cmd.op == OP_APPEND_WR && i_cmd.step[1:0] == 2'd3) begin
            r_segcnt <= r_segcnt + SCW'(1);
        end
    end

    // mirrored tangent, one 18x32 multiplier shared over coordinates
    always_comb begin
        case (coord)
            2'd0:    dsel = r_d[0];
            2'd1:    dsel = r_d[1];
            default: dsel = r_d[2];
        endcase
        opa   = (phase == 2'd0) ? $signed({1'b0, dsel[16:0]}) : $signed({dsel[33], dsel[33:17]});
        mprod = opa * r_item.tangent_factor;
    end

    // evaluate arithmetic
    always_comb begin
        tc     = (r_item.param_t > 17'd65470) ? 16'd65470 : r_item.param_t[15:0];
        scaled = tc * r_segcnt;
        segraw = scaled[16+SCW-1:16];
        u      = 17'h10000 - {1'b0, r_lt};
        m3     = r_ll * r_lt;
        m2     = r_ll * r_u;
        m1     = r_lu * r_u;
        m2x3   = {m2, 1'b0} + {2'b00, m2};
        m1x3   = {m1, 1'b0} + {2'b00, m1};
        case (i_cmd.step[1:0])
            2'd1:    wsel = r_w0;
            2'd2:    wsel = {1'b0, r_w1};
            2'd3:    wsel = {1'b0, r_w2};
            default: wsel = {1'b0, r_w3};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_res  <= t_out_item'{out_x: '0, out_y: '0, out_z: '0,
                                  status: (i_item.action == ACT_APPEND) && full};
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
        case (i_cmd.op)
            OP_APPEND_RD1: r_p0 <= r_rd;
            OP_APPEND_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= ($signed(34'(signed'(r_p0[32*k +: 32]))) <<< 1)
                              - 34'(signed'(r_rd[32*k +: 32]));
                end
            end
            OP_APPEND_MUL: begin
                case (phase)
                    2'd0: r_prod <= 67'(mprod);
                    2'd1: r_prod <= r_prod + (67'(mprod) <<< 17);
                    default: begin
                        r_tan[coord] <= f_sat((r_prod + (r_prod[66] ? RND_NEG : RND_POS))
                                              >>> COORD_FRAC_BITS);
                    end
                endcase
            end
            OP_EVAL_SEG: begin
                r_seg <= (32'(segraw) >= 32'(MAX_SEGMENTS)) ? SCW'(MAX_SEGMENTS - 1) : segraw;
                r_lt  <= scaled[15:0];
            end
            OP_EVAL_SQ: begin
                r_u  <= u;
                r_ll <= r_lt * r_lt;
                r_lu <= r_lt * u;
            end
            OP_EVAL_W: begin
                r_w3 <= m3[47:18];
                r_w2 <= m2x3[47:18];
                r_w1 <= m1x3[47:18];
            end
            OP_EVAL_W0: begin
                r_w0 <= 31'h40000000 - {1'b0, r_w1} - {1'b0, r_w2} - {1'b0, r_w3};
            end
            OP_EVAL_MAC: begin
                if (i_cmd.step != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= ((i_cmd.step == STEP_W'(1)) ? 64'sd0 : r_acc[k])
                                    + $signed(r_rd[32*k +: 32]) * $signed({1'b0, wsel});
                    end
                end
            end
            OP_EVAL_RND: begin
                r_res.out_x <= f_sat((67'(r_acc[0]) + RND_Q30) >>> 30);
                r_res.out_y <= f_sat((67'(r_acc[1]) + RND_Q30) >>> 30);
                r_res.out_z <= f_sat((67'(r_acc[2]) + RND_Q30) >>> 30);
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_segcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_segcnt) >= 1) && (32'(r_segcnt) <= 32'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_seg_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EVAL_MAC) |-> (32'(r_seg) < 32'(MAX_SEGMENTS)))
        else $error("evaluated segment beyond table");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_APPEND_WR) |-> !full)
        else $error("append written into a full table");
`endif

endmodule

// File: sv/piecewise_cubic_bezier_eval_core.sv
// ----------------------------------------------------------------------------
// piecewise_cubic_bezier_eval_core: piecewise cubic bezier evaluator
// table of 3d control points, segment append and curve evaluation
// ----------------------------------------------------------------------------
// usage
//   i_in carries one transaction per item: write point, append segment,
//   evaluate, or no-op; o_out returns exactly one result transaction each
//   items are taken one at a time; i_in.ready is high only while idle
//   sequencer steps from acceptance to o_out.valid:
//     write: table write; no-op / refused append: straight to the result
//     append: two table reads, difference, nine steps of the shared
//       18x32 tangent multiplier, four table writes
//     evaluate: segment pick, two weight multiply stages, weight sum,
//       four table reads into three 32x32 mac lanes, rounding
//   the next item can be taken in the cycle after the result is handed over
//   o_out holds in its own register, so a stalled receiver blocks only
//   the handover of the next result, not acceptance of the next item
//   reset sets the segment count to one and empties the result channel;
//   control point entries are undefined until written
// ----------------------------------------------------------------------------
module piecewise_cubic_bezier_eval_core #(
    parameter int MAX_SEGMENTS    = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcbe_in_if.sink     i_in,
    pcbe_out_if.source  o_out
);
    import pcbe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: one-hot state machine, step counter, result valid
    pcbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_action    (i_in.data.action),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready)
    );

    // datapath: table memory, arithmetic, result registers
    pcbe_dp #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in.data),
        .o_sts   (sts),
        .o_out   (o_out.data)
    );

endmodule

// File: tb/pcbe_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench channel note
// the block's own channel interfaces (pcbe_in_if, pcbe_out_if) are used as is
// ----------------------------------------------------------------------------
package pcbe_tb_pkg;
    import pcbe_pkg::*;
    localparam int TB_MAX_SEGMENTS = 16;
    localparam int TB_TABLE_SIZE   = 4 * TB_MAX_SEGMENTS;
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam logic [16:0] T_CLAMP = 17'd65470;
endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checks the piecewise cubic bezier evaluator
// drives write, append, evaluate and no-op transactions with random idling
// on both channels; a scoreboard predicts each result and compares it
// ----------------------------------------------------------------------------
import pcbe_pkg::*;
import pcbe_tb_pkg::*;

class curve_scoreboard;
    logic signed [31:0] pts [TB_TABLE_SIZE][3];
    bit                 written [TB_TABLE_SIZE];
    int unsigned        seg_count;
    t_out_item          pending [$];
    int                 errors;
    int                 n_eval;
    int                 n_full;
    int                 n_append;

    function void clear();
        seg_count = 1;
        errors = 0;
        foreach (written[i]) written[i] = 0;
    endfunction

    // tangent: (d*f) >> 16, half away from zero, saturated
    function logic signed [31:0] scale_tangent(longint d, longint f);
        bit neg;
        logic [127:0] md, mf, prod, mag;
        neg = (d < 0) != (f < 0);
        md = (d < 0) ? -d : d;
        mf = (f < 0) ? -f : f;
        prod = md * mf;
        mag = (prod + 128'd32768) >> 16;
        if (neg) return (mag >= 128'h80000000) ? 32'sh80000000 : -mag[31:0];
        return (mag > 128'h7fffffff) ? 32'sh7fffffff : mag[31:0];
    endfunction

    function logic signed [31:0] round_sat(longint s);
        longint b, q;
        b = s + (64'sd1 << 29);
        q = b >>> 30;
        if (q > 64'sd2147483647) return 32'sh7fffffff;
        if (q < -64'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    // note an accepted input transaction and queue its expected result
    function void note_input(t_in_item it);
        t_out_item r;
        int unsigned base;
        longint seg;
        longint t, sc, lt, u, w[4], acc;
        r = '0;
        case (it.action)
            ACT_WRITE: begin
                if (it.point_index < TB_TABLE_SIZE) begin
                    pts[it.point_index][0] = it.ax;
                    pts[it.point_index][1] = it.ay;
                    pts[it.point_index][2] = it.az;
                    written[it.point_index] = 1;
                    if (it.point_index == 0) seg_count = 1;
                end
            end
            ACT_APPEND: begin
                if (seg_count >= TB_MAX_SEGMENTS) begin
                    r.status = 1;
                    n_full++;
                end else begin
                    base = seg_count * 4;
                    for (int k = 0; k < 3; k++) begin
                        pts[base][k] = pts[base-1][k];
                        pts[base+1][k] = scale_tangent(2 * longint'(pts[base-1][k])
                            - longint'(pts[base-2][k]), longint'(it.tangent_factor));
                    end
                    pts[base+2][0] = it.ax; pts[base+2][1] = it.ay;
                    pts[base+2][2] = it.az;
                    pts[base+3][0] = it.bx; pts[base+3][1] = it.by_coord;
                    pts[base+3][2] = it.bz;
                    for (int j = 0; j < 4; j++) written[base+j] = 1;
                    seg_count++;
                    n_append++;
                end
            end
            ACT_EVAL: begin
                t = (it.param_t > T_CLAMP) ? T_CLAMP : it.param_t;
                sc = t * seg_count;
                seg = sc >> 16;
                if (seg >= TB_MAX_SEGMENTS) seg = TB_MAX_SEGMENTS - 1;
                lt = sc & 64'hffff;
                u = 65536 - lt;
                w[3] = (lt * lt * lt) >> 18;
                w[2] = (3 * lt * lt * u) >> 18;
                w[1] = (3 * lt * u * u) >> 18;
                w[0] = (64'sd1 << 30) - w[1] - w[2] - w[3];
                for (int k = 0; k < 3; k++) begin
                    acc = 0;
                    for (int j = 0; j < 4; j++)
                        acc += longint'(pts[seg*4+j][k]) * w[j];
                    if (k == 0) r.out_x = round_sat(acc);
                    else if (k == 1) r.out_y = round_sat(acc);
                    else r.out_z = round_sat(acc);
                end
                n_eval++;
            end
            default: ;
        endcase
        pending = {pending, r};
    endfunction

    // is the evaluate segment fully written
    function bit eval_safe(logic [16:0] pt);
        longint t, seg;
        t = (pt > T_CLAMP) ? T_CLAMP : pt;
        seg = (t * seg_count) >> 16;
        for (int j = 0; j < 4; j++) if (!written[seg*4+j]) return 0;
        return 1;
    endfunction

    function void check_result(t_out_item got);
        t_out_item e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.out_x !== e.out_x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.out_x, got.out_x);
            errors++;
        end
        if (got.out_y !== e.out_y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.out_y, got.out_y);
            errors++;
        end
        if (got.out_z !== e.out_z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.out_z, got.out_z);
            errors++;
        end
        if (got.status !== e.status) begin
            $display("%0t: status expected %b actual %b", $time, e.status, got.status);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;

    pcbe_in_if  in_ch ();
    pcbe_out_if out_ch ();

    piecewise_cubic_bezier_eval_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    curve_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycles;
    int  n_items;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall, check on every handshake
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        endcase
    endfunction

    // one transaction, held until accepted
    task automatic send(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        n_items++;
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [1:0] act);
        t_in_item it;
        it.action = act;
        it.point_index = 6'($urandom);
        it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
        it.bx = rand_coord(); it.by_coord = rand_coord(); it.bz = rand_coord();
        it.tangent_factor = ($urandom_range(3) == 0) ? $urandom
                                                     : $urandom_range(0, 32'h30000);
        it.param_t = ($urandom_range(7) == 0) ? 17'($urandom)
                                              : 17'($urandom_range(65536));
        return it;
    endfunction

    task automatic write_seg0();
        t_in_item it;
        for (int i = 0; i < 4; i++) begin
            it = make_item(ACT_WRITE);
            it.point_index = 6'(i);
            send(it);
        end
    endtask

    task automatic random_item();
        t_in_item it;
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            write_seg0();
        end else if (r < 35) begin
            send(make_item(ACT_APPEND));
        end else if (r < 80) begin
            it = make_item(ACT_EVAL);
            if (sb.eval_safe(it.param_t)) send(it);
        end else if (r < 95) begin
            it = make_item(ACT_WRITE);
            // writes only to entries already in use
            if (it.point_index < TB_TABLE_SIZE && !sb.written[it.point_index])
                it.point_index = 6'($urandom_range(3));
            send(it);
        end else begin
            send(make_item(ACT_NOP));
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_item it;
        sb = new();
        sb.clear();
        cycles = 0;
        n_items = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: first segment, extremes of t, append, full table
        write_seg0();
        it = make_item(ACT_EVAL);
        it.param_t = 17'd0; send(it);
        it.param_t = 17'd65536; send(it);
        it.param_t = 17'h1ffff; send(it);
        it.param_t = T_CLAMP; send(it);
        it = make_item(ACT_APPEND);
        it.tangent_factor = 32'sh7fffffff; send(it);
        it = make_item(ACT_APPEND);
        it.tangent_factor = 32'sh80000000; send(it);
        it = make_item(ACT_APPEND);
        it.tangent_factor = 32'sh00010000; send(it);
        it = make_item(ACT_WRITE);
        it.point_index = 6'd63; send(it);
        send(make_item(ACT_NOP));
        while (sb.seg_count < TB_MAX_SEGMENTS) send(make_item(ACT_APPEND));
        send(make_item(ACT_APPEND));
        it = make_item(ACT_EVAL);
        it.param_t = 17'h1ffff; send(it);
        it.param_t = 17'd32768; send(it);

        // random phases with different idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 25 : 0;
            for (int i = 0; i < 300; i++) begin
                random_item();
                if (i == 150) drain();
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d transactions: %0d evaluations, %0d appends, %0d refused",
                 n_items, sb.n_eval, sb.n_append, sb.n_full);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
